### hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/hbpwm_pkg.sv
package hbpwm_pkg;

    localparam int CNT_W   = 16;
    localparam int CMD_W   = 14;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // pin bit positions
    localparam int PIN_LL = 0;
    localparam int PIN_RL = 1;
    localparam int PIN_LH = 2;
    localparam int PIN_RH = 3;

    localparam logic signed [CMD_W-1:0] CMD_MAX = 14'sd8191;
    localparam logic signed [CMD_W-1:0] CMD_MIN = -14'sd8192;

    typedef enum logic [IDX_W-1:0] {
        REG_DRIVE_MODE   = 3'd0,
        REG_PWM_INVERT   = 3'd1,
        REG_DIR_INVERT   = 3'd2,
        REG_PERIOD_TICKS = 3'd3,
        REG_DEAD_TICKS   = 3'd4,
        REG_DEADBAND     = 3'd5,
        REG_DUTY_LIMIT   = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic        drive_mode;
        logic        pwm_invert;
        logic        dir_invert;
        logic [15:0] period_ticks;
        logic [7:0]  dead_ticks;
        logic [12:0] deadband;
        logic [15:0] duty_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        drive_mode:   1'b1,
        pwm_invert:   1'b0,
        dir_invert:   1'b0,
        period_ticks: 16'd5001,
        dead_ticks:   8'd4,
        deadband:     13'd10,
        duty_limit:   16'd5000
    };

    // magnitude of a stored command, clamped to the duty limit
    function automatic logic [15:0] cmd_mag(input logic signed [CMD_W-1:0] cmd,
                                            input logic [15:0] limit);
        logic [CMD_W-1:0] m;
        logic [15:0]      m16;
        m   = cmd[CMD_W-1] ? CMD_W'(-cmd) : CMD_W'(cmd);
        m16 = 16'(m);
        return (m16 > limit) ? limit : m16;
    endfunction

endpackage

### hw/rtl/hbpwm_cmd.sv
module hbpwm_cmd (
    input  logic signed [15:0]                   i_power,
    input  hbpwm_pkg::t_cfg                      i_cfg,
    output logic signed [hbpwm_pkg::CMD_W-1:0]   o_cmd
);
    import hbpwm_pkg::*;

    logic signed [16:0] ext;
    logic        [16:0] mag;

    assign ext = {i_power[15], i_power};
    assign mag = i_power[15] ? 17'(-ext) : 17'(ext);

    always_comb begin
        if (mag < {4'b0, i_cfg.deadband}) begin
            o_cmd = '0;
        end else if (i_power > 16'(CMD_MAX)) begin
            o_cmd = CMD_MAX;
        end else if (i_power < 16'(CMD_MIN)) begin
            o_cmd = CMD_MIN;
        end else begin
            o_cmd = i_power[CMD_W-1:0];
        end
    end

endmodule

### hw/rtl/h_bridge_pwm_motor_drive.sv
// sign-magnitude h-bridge pwm drive
// input channel (i_in_valid / o_in_ready): each item is either a timer tick
// (i_mode 0) or a new signed power command (i_mode 1, i_power)
// output channel (o_out_valid / i_out_ready): one item per input item with the
// four bridge pin levels after that item and a flag for a new pwm period
// config channel (i_cfg_valid / o_cfg_ready): register index and data, always
// ready; writes must be made while the block is idle; the block does not enforce this
// an accepted item passes the input register, then the state update and result
// register; a stalled receiver can hold it in the input register
// throughput: one item per cycle while the receiver does not stall, set by the state update loop
// reset: pins low, counter, command, duty and dead time cleared, registers
// at their defaults; no item is held
// a stalled receiver holds the result register; once the input register holds an
// item, it and o_in_ready then hold too, so nothing is lost or repeated
// writing a new drive mode clears the command, duty, pins and counter
module h_bridge_pwm_motor_drive (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic signed [15:0]             i_power,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_left_low,
    output logic                           o_right_low,
    output logic                           o_left_high,
    output logic                           o_right_high,
    output logic                           o_period_start,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hbpwm_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [hbpwm_pkg::DATA_W-1:0]   i_cfg_data
);
    import hbpwm_pkg::*;
    `include "assert_macros.svh"

    t_cfg r_cfg;

    // input stage
    logic                     r_in_valid;
    logic                     r_mode;
    logic signed [15:0]       r_power;

    // drive state
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [CMD_W-1:0]  r_cmd, n_cmd;
    logic [15:0]              r_duty, n_duty;
    logic [7:0]               r_dcnt, n_dcnt;
    logic                     r_pend, n_pend;
    logic [3:0]               r_pins, n_pins;
    logic                     n_start;

    // result stage
    logic                     r_out_valid;
    logic [3:0]               r_out_pins;
    logic                     r_out_start;

    logic                     adv;
    logic                     cfg_wr;
    logic signed [CMD_W-1:0]  new_cmd;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    hbpwm_cmd u_cmd (
        .i_power (r_power),
        .i_cfg   (r_cfg),
        .o_cmd   (new_cmd)
    );

    always_comb begin
        n_cnt   = r_cnt;
        n_cmd   = r_cmd;
        n_duty  = r_duty;
        n_dcnt  = r_dcnt;
        n_pend  = r_pend;
        n_pins  = r_pins;
        n_start = 1'b0;
        if (r_mode) begin
            n_cmd = new_cmd;
            if (new_cmd == '0) begin
                n_duty = '0;
                n_pend = 1'b0;
                n_dcnt = '0;
                if (r_cfg.drive_mode) begin
                    n_pins = '0;
                end else begin
                    n_pins = {2'b00, r_cfg.dir_invert, r_cfg.pwm_invert};
                end
            end else begin
                n_duty = cmd_mag(new_cmd, r_cfg.duty_limit);
            end
        end else begin
            // period start
            if (r_cnt == '0) begin
                n_start = 1'b1;
                if (r_cfg.drive_mode) begin
                    n_pins = '0;
                end else begin
                    n_pins[PIN_LH] = 1'b0;
                    n_pins[PIN_RH] = 1'b0;
                    n_pins[PIN_LL] = r_cfg.pwm_invert;
                end
                if (r_cmd != '0) begin
                    n_pend = 1'b1;
                    n_dcnt = r_cfg.dead_ticks;
                end
            end
            // dead time countdown and latch
            if (n_pend) begin
                if (n_dcnt == '0) begin
                    n_pend = 1'b0;
                    if (r_cmd != '0) begin
                        n_duty = cmd_mag(r_cmd, r_cfg.duty_limit);
                        if (r_cfg.drive_mode) begin
                            if ((r_cmd > 0) ^ r_cfg.pwm_invert) begin
                                n_pins[PIN_LL] = 1'b1;
                                n_pins[PIN_RH] = 1'b1;
                            end else begin
                                n_pins[PIN_RL] = 1'b1;
                                n_pins[PIN_LH] = 1'b1;
                            end
                        end else begin
                            n_pins[PIN_LL] = !r_cfg.pwm_invert;
                        end
                    end
                end else begin
                    n_dcnt = n_dcnt - 8'd1;
                end
            end
            // duty compare
            if (r_cnt == n_duty) begin
                if (r_cfg.drive_mode) begin
                    n_pins = '0;
                end else begin
                    n_pins[PIN_LL] = r_cfg.pwm_invert;
                    n_pins[PIN_RL] = r_cmd[CMD_W-1] ^ r_cfg.dir_invert;
                end
            end
            if (r_cnt >= r_cfg.period_ticks || r_cnt == '1) begin
                n_cnt = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_cmd       <= '0;
            r_duty      <= '0;
            r_dcnt      <= '0;
            r_pend      <= 1'b0;
            r_pins      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_cnt  <= n_cnt;
                r_cmd  <= n_cmd;
                r_duty <= n_duty;
                r_dcnt <= n_dcnt;
                r_pend <= n_pend;
                r_pins <= n_pins;
            end
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    REG_DRIVE_MODE: begin
                        if (i_cfg_data[0] != r_cfg.drive_mode) begin
                            r_cnt  <= '0;
                            r_cmd  <= '0;
                            r_duty <= '0;
                            r_dcnt <= '0;
                            r_pend <= 1'b0;
                            r_pins <= '0;
                        end
                        r_cfg.drive_mode <= i_cfg_data[0];
                    end
                    REG_PWM_INVERT:   r_cfg.pwm_invert   <= i_cfg_data[0];
                    REG_DIR_INVERT:   r_cfg.dir_invert   <= i_cfg_data[0];
                    REG_PERIOD_TICKS: r_cfg.period_ticks <= i_cfg_data;
                    REG_DEAD_TICKS:   r_cfg.dead_ticks   <= i_cfg_data[7:0];
                    REG_DEADBAND:     r_cfg.deadband     <= i_cfg_data[12:0];
                    REG_DUTY_LIMIT:   r_cfg.duty_limit   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_mode  <= i_mode;
            r_power <= i_power;
        end
        if (adv) begin
            r_out_pins  <= n_pins;
            r_out_start <= n_start;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_low     = r_out_pins[PIN_LL];
    assign o_right_low    = r_out_pins[PIN_RL];
    assign o_left_high    = r_out_pins[PIN_LH];
    assign o_right_high   = r_out_pins[PIN_RH];
    assign o_period_start = r_out_start;

    // no shoot-through on either leg
    `ASSERT_ALWAYS(a_no_shoot, !(r_pins[PIN_LL] && r_pins[PIN_LH]) && !(r_pins[PIN_RL] && r_pins[PIN_RH]), "bridge leg shoot-through")
    // high-side switches stay off with a single pwm pin
    `ASSERT_ALWAYS(a_one_pwm_high_off, r_cfg.drive_mode || (!r_pins[PIN_LH] && !r_pins[PIN_RH]), "high side on in single pwm mode")
    // dead time only pends for a live command
    `ASSERT_ALWAYS(a_pend_cmd, !r_pend || (r_cmd != '0), "dead time pending with zero command")
    // an advancing item always lands in the result register
    `ASSERT_NEXT(a_adv_out, adv, r_out_valid, "advanced item missing from result register")

endmodule
